// File: rtl/lcd4_pkg.sv
// Shared types, codes and constant tables for the 4-bit character LCD controller.
package lcd4_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int PULSE_W     = 10;
  localparam int HOLD_W      = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int STEP_W      = 5;
  localparam int INIT_LAST   = 28;
  localparam int BYTE_LAST   = 3;

  localparam logic [PULSE_W-1:0] PULSE_RESET = 10'd40;
  localparam logic [HOLD_W-1:0]  POWER_RESET = 20'd50000;

  localparam logic [7:0] ADDR_ROW1  = 8'h80;
  localparam logic [7:0] ADDR_ROW2  = 8'hC0;
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] CMD_HOME   = 8'h02;

  typedef enum logic [2:0] {
    OP_DATA   = 3'd0,
    OP_CMD    = 3'd1,
    OP_INIT   = 3'd2,
    OP_CURSOR = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_HOME   = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE = 2'd0,
    CFG_POWER = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EX_NONE,
    EX_1000,
    EX_2000,
    EX_5000,
    EX_10000
  } extra_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [6:0] column;
  } in_item_t;

  typedef struct packed {
    logic              reg_select;
    logic              read_not_write;
    logic              enable_pin;
    logic [3:0]        nibble;
    logic [HOLD_W-1:0] hold_us;
    logic              last;
  } out_item_t;

  // One classified request as it waits for the sequencer.
  typedef struct packed {
    logic       is_init;
    logic       reg_select;
    logic [7:0] cmd_byte;
    extra_t     extra;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [3:0] nib;
    extra_t     extra;
  } init_nib_t;

  function automatic logic [13:0] extra_us(input extra_t code);
    logic [13:0] v;
    unique case (code)
      EX_NONE:  v = 14'd0;
      EX_1000:  v = 14'd1000;
      EX_2000:  v = 14'd2000;
      EX_5000:  v = 14'd5000;
      EX_10000: v = 14'd10000;
      default:  v = 14'd0;
    endcase
    return v;
  endfunction

  // Power-on nibble sequence: four wake-up nibbles, then five command bytes.
  function automatic init_nib_t init_nib(input logic [3:0] idx);
    init_nib_t e;
    unique case (idx)
      4'd0:    e = '{nib: 4'h3, extra: EX_5000};
      4'd1:    e = '{nib: 4'h3, extra: EX_1000};
      4'd2:    e = '{nib: 4'h3, extra: EX_10000};
      4'd3:    e = '{nib: 4'h2, extra: EX_10000};
      4'd4:    e = '{nib: 4'h2, extra: EX_NONE};
      4'd5:    e = '{nib: 4'h8, extra: EX_1000};
      4'd6:    e = '{nib: 4'h0, extra: EX_NONE};
      4'd7:    e = '{nib: 4'h8, extra: EX_1000};
      4'd8:    e = '{nib: 4'h0, extra: EX_NONE};
      4'd9:    e = '{nib: 4'h1, extra: EX_1000};
      4'd10:   e = '{nib: 4'h0, extra: EX_NONE};
      4'd11:   e = '{nib: 4'h6, extra: EX_1000};
      4'd12:   e = '{nib: 4'h0, extra: EX_NONE};
      4'd13:   e = '{nib: 4'hC, extra: EX_NONE};
      default: e = '{nib: 4'h0, extra: EX_NONE};
    endcase
    return e;
  endfunction

endpackage

// File: rtl/lcd4_front.sv
// Request classifier: turns an accepted request into a sequencer descriptor.
module lcd4_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lcd4_pkg::in_item_t    in_data,
  input  lcd4_pkg::queue_stat_t q_stat,
  output logic                  push,
  output lcd4_pkg::desc_t       push_desc
);
  import lcd4_pkg::*;

  logic       emits;
  logic [7:0] addr;

  assign in_ready = !q_stat.full;

  // Column counts from 1; column zero wraps to the top address.
  assign addr = 8'({1'b0, in_data.column}) - 8'd1;

  always_comb begin
    emits     = 1'b1;
    push_desc = '{is_init: 1'b0, reg_select: 1'b0, cmd_byte: in_data.byte_value,
                  extra: EX_NONE};
    unique case (in_data.operation)
      OP_DATA: begin
        push_desc.reg_select = 1'b1;
      end
      OP_CMD: begin
      end
      OP_INIT: begin
        push_desc.is_init = 1'b1;
      end
      OP_CURSOR: begin
        if (in_data.row == 2'd1) begin
          push_desc.cmd_byte = addr | ADDR_ROW1;
        end else if (in_data.row == 2'd2) begin
          push_desc.cmd_byte = addr | ADDR_ROW2;
        end else begin
          emits = 1'b0;
        end
      end
      OP_CLEAR: begin
        push_desc.cmd_byte = CMD_CLEAR;
        push_desc.extra    = EX_2000;
      end
      OP_HOME: begin
        push_desc.cmd_byte = CMD_HOME;
        push_desc.extra    = EX_2000;
      end
      default: begin
        emits = 1'b0;
      end
    endcase
  end

  // Drop requests that produce no pin steps.
  assign push = in_valid && in_ready && emits;

endmodule

// File: rtl/lcd4_queue.sv
// Small descriptor queue between the classifier and the sequencer.
module lcd4_queue #(
  parameter int DEPTH = lcd4_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lcd4_pkg::desc_t       push_desc,
  input  logic                  pop,
  output lcd4_pkg::desc_t       pop_desc,
  output lcd4_pkg::queue_stat_t q_stat
);
  import lcd4_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_desc     = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

// File: rtl/lcd4_back.sv
// Pin-step sequencer: walks a descriptor, one step per cycle unless stalled.
module lcd4_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lcd4_pkg::queue_stat_t         q_stat,
  input  lcd4_pkg::desc_t               pop_desc,
  output logic                          pop,
  input  logic [lcd4_pkg::PULSE_W-1:0]  pulse_us,
  input  logic [lcd4_pkg::HOLD_W-1:0]   power_on_wait_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lcd4_pkg::out_item_t           out_data
);
  import lcd4_pkg::*;

  back_state_t       state_r, state_nxt;
  desc_t             desc_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r;

  logic              load;
  logic              step_last;
  out_item_t         step_item;
  logic [STEP_W-1:0] s1;
  init_nib_t         ient;
  logic [3:0]        nib;
  extra_t            extra;
  logic              en;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (load && step_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Step contents
  always_comb begin
    s1    = step_r - 1'b1;
    ient  = init_nib(s1[4:1]);
    nib   = 4'h0;
    extra = EX_NONE;
    en    = 1'b0;
    if (desc_r.is_init) begin
      en        = !s1[0];
      nib       = ient.nib;
      extra     = ient.extra;
      step_last = (step_r == STEP_W'(INIT_LAST));
    end else begin
      en        = !step_r[0];
      nib       = step_r[1] ? desc_r.cmd_byte[3:0] : desc_r.cmd_byte[7:4];
      extra     = step_r[1] ? desc_r.extra : EX_NONE;
      step_last = (step_r == STEP_W'(BYTE_LAST));
    end
    step_item.reg_select     = desc_r.reg_select;
    step_item.read_not_write = 1'b0;
    step_item.enable_pin     = en;
    step_item.nibble         = nib;
    step_item.hold_us        = en ? HOLD_W'(pulse_us)
                                  : HOLD_W'(pulse_us) + HOLD_W'(extra_us(extra));
    step_item.last           = step_last;
    // Idle wait step ahead of the init nibbles
    if (desc_r.is_init && step_r == '0) begin
      step_item.enable_pin = 1'b0;
      step_item.nibble     = 4'h0;
      step_item.hold_us    = power_on_wait_us;
    end
  end

  // Outputs and handshake
  always_comb begin
    pop           = (state_r == ST_IDLE) && !q_stat.empty;
    load          = (state_r == ST_RUN) && (!out_valid_r || out_ready);
    step_nxt      = pop ? '0 : (load ? step_r + 1'b1 : step_r);
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      desc_r <= pop_desc;
    end
    if (load) begin
      out_r <= step_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/char_lcd_nibble_interface.sv
// 4-bit character LCD controller: classifier, descriptor queue and step sequencer.
// A taken request passes the queue and the sequencer state before its first pin step
// is registered at the output. Throughput: one pin step per cycle while out_ready allows;
// between requests the sequencer returns to idle; the queue absorbs requests meanwhile.
// Requests that emit no steps are dropped at the input in the cycle they are taken.
// Reset (rst_n low, synchronous) empties the queue and sets pulse_us 40, power wait 50000.
module char_lcd_nibble_interface #(
  parameter int QUEUE_DEPTH = lcd4_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lcd4_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output lcd4_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lcd4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcd4_pkg::HOLD_W-1:0]     cfg_data
);
  import lcd4_pkg::*;

  logic [PULSE_W-1:0] pulse_r, pulse_nxt;
  logic [HOLD_W-1:0]  power_r, power_nxt;

  queue_stat_t q_stat;
  logic        push;
  logic        pop;
  desc_t       push_desc;
  desc_t       pop_desc;

  assign cfg_ready = 1'b1;

  always_comb begin
    pulse_nxt = pulse_r;
    power_nxt = power_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_PULSE) begin
        pulse_nxt = cfg_data[PULSE_W-1:0];
      end else if (cfg_index == CFG_POWER) begin
        power_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r <= PULSE_RESET;
      power_r <= POWER_RESET;
    end else begin
      pulse_r <= pulse_nxt;
      power_r <= power_nxt;
    end
  end

  lcd4_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_desc (push_desc)
  );

  lcd4_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .q_stat    (q_stat)
  );

  lcd4_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .pop_desc         (pop_desc),
    .pop              (pop),
    .pulse_us         (pulse_r),
    .power_on_wait_us (power_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

endmodule

// File: tb/sv/tb_char_lcd_nibble_interface.sv
// Self-checking testbench for the 4-bit character LCD controller.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_interface;
  import lcd4_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  // codes the package enum leaves out: the block must drop these requests
  localparam logic [2:0] OP_RSVD_A = 3'd6;
  localparam logic [2:0] OP_RSVD_B = 3'd7;

  localparam logic [1:0] ROW_NONE   = 2'd0;
  localparam logic [1:0] ROW_TOP    = 2'd1;
  localparam logic [1:0] ROW_BOTTOM = 2'd2;
  localparam logic [1:0] ROW_EXTRA  = 2'd3;

  localparam logic [3:0] NIB_WAKE = 4'h3;
  localparam logic [3:0] NIB_BUS4 = 4'h2;

  localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_DISP_ON    = 8'h0C;

  localparam logic [HOLD_W-1:0] EXTRA_NONE  = 20'd0;
  localparam logic [HOLD_W-1:0] EXTRA_SHORT = 20'd1000;
  localparam logic [HOLD_W-1:0] EXTRA_CLEAR = 20'd2000;
  localparam logic [HOLD_W-1:0] EXTRA_WAKE  = 20'd5000;
  localparam logic [HOLD_W-1:0] EXTRA_LONG  = 20'd10000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PULSE;
  logic [HOLD_W-1:0]    cfg_data  = '0;

  // register shadow, as the block should hold it
  logic [PULSE_W-1:0] pulse_cfg = PULSE_RESET;
  logic [HOLD_W-1:0]  power_cfg = POWER_RESET;

  out_item_t pin_steps_q[$];
  out_item_t want;
  int        n_fail         = 0;
  int        quiet_cycles   = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  char_lcd_nibble_interface u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------- pin step predictor
  function automatic void push_step(input logic rs, input logic en, input logic [3:0] nib,
                                    input logic [HOLD_W-1:0] hold, input logic fin);
    out_item_t s;
    s.reg_select     = rs;
    s.read_not_write = 1'b0;
    s.enable_pin     = en;
    s.nibble         = nib;
    s.hold_us        = hold;
    s.last           = fin;
    pin_steps_q.push_back(s);
  endfunction

  function automatic void push_nibble(input logic rs, input logic [3:0] nib,
                                      input logic [HOLD_W-1:0] extra, input logic fin);
    logic [HOLD_W-1:0] low_hold;
    low_hold = HOLD_W'(pulse_cfg) + extra;
    push_step(rs, 1'b1, nib, HOLD_W'(pulse_cfg), 1'b0);
    push_step(rs, 1'b0, nib, low_hold, fin);
  endfunction

  function automatic void push_byte(input logic rs, input logic [7:0] b,
                                    input logic [HOLD_W-1:0] extra, input logic fin);
    push_nibble(rs, b[7:4], EXTRA_NONE, 1'b0);
    push_nibble(rs, b[3:0], extra, fin);
  endfunction

  // Queue the pin steps one request should produce; return how many.
  function automatic int predict_steps(input in_item_t req);
    int         queued_at_start;
    logic [7:0] addr;
    queued_at_start = pin_steps_q.size();
    addr = {1'b0, req.column} - 8'd1;  // column zero wraps to 0xFF
    case (req.operation)
      OP_DATA:   push_byte(1'b1, req.byte_value, EXTRA_NONE, 1'b1);
      OP_CMD:    push_byte(1'b0, req.byte_value, EXTRA_NONE, 1'b1);
      OP_INIT: begin
        push_step(1'b0, 1'b0, 4'h0, power_cfg, 1'b0);
        push_nibble(1'b0, NIB_WAKE, EXTRA_WAKE, 1'b0);
        push_nibble(1'b0, NIB_WAKE, EXTRA_SHORT, 1'b0);
        push_nibble(1'b0, NIB_WAKE, EXTRA_LONG, 1'b0);
        push_nibble(1'b0, NIB_BUS4, EXTRA_LONG, 1'b0);
        push_byte(1'b0, CMD_FUNC_SET, EXTRA_SHORT, 1'b0);
        push_byte(1'b0, CMD_DISP_OFF, EXTRA_SHORT, 1'b0);
        push_byte(1'b0, CMD_CLEAR, EXTRA_SHORT, 1'b0);
        push_byte(1'b0, CMD_ENTRY_MODE, EXTRA_SHORT, 1'b0);
        push_byte(1'b0, CMD_DISP_ON, EXTRA_NONE, 1'b1);
      end
      OP_CURSOR: begin
        if (req.row == ROW_TOP) begin
          push_byte(1'b0, addr | ADDR_ROW1, EXTRA_NONE, 1'b1);
        end else if (req.row == ROW_BOTTOM) begin
          push_byte(1'b0, addr | ADDR_ROW2, EXTRA_NONE, 1'b1);
        end
      end
      OP_CLEAR:  push_byte(1'b0, CMD_CLEAR, EXTRA_CLEAR, 1'b1);
      OP_HOME:   push_byte(1'b0, CMD_HOME, EXTRA_CLEAR, 1'b1);
      default: ;
    endcase
    return pin_steps_q.size() - queued_at_start;
  endfunction

  // ---------------------------------------------------------------- drivers
  function automatic in_item_t make_request(input logic [2:0] op, input logic [7:0] b,
                                            input logic [1:0] row, input logic [6:0] col);
    in_item_t r;
    r.operation  = op;
    r.byte_value = b;
    r.row        = row;
    r.column     = col;
    return r;
  endfunction

  function automatic in_item_t rand_request();
    in_item_t r;
    int       pick;
    r.byte_value = 8'($urandom_range(255));
    r.row        = 2'($urandom_range(3));
    r.column     = 7'($urandom_range(127));
    pick = $urandom_range(99);
    if (pick < 30) begin
      r.operation = OP_DATA;
    end else if (pick < 52) begin
      r.operation = OP_CMD;
    end else if (pick < 57) begin
      r.operation = OP_INIT;
    end else if (pick < 80) begin
      r.operation = OP_CURSOR;
      // mostly valid rows and on-screen columns
      if ($urandom_range(9) != 0) r.row = $urandom_range(1) ? ROW_TOP : ROW_BOTTOM;
      if ($urandom_range(4) != 0) r.column = 7'($urandom_range(64, 1));
    end else if (pick < 88) begin
      r.operation = OP_CLEAR;
    end else if (pick < 96) begin
      r.operation = OP_HOME;
    end else begin
      r.operation = $urandom_range(1) ? OP_RSVD_A : OP_RSVD_B;
    end
    return r;
  endfunction

  // Offer one request, hold it until taken, then queue its expected steps.
  task automatic send_request(input in_item_t req, output int emitted);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    emitted = predict_steps(req);
  endtask

  // Write one register once every queued step has come out and the sequencer is idle.
  task automatic write_reg(input cfg_idx_t idx, input logic [HOLD_W-1:0] value);
    in_valid <= 1'b0;
    while (pin_steps_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_PULSE) pulse_cfg = value[PULSE_W-1:0];
    else power_cfg = value;
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed_requests();
    int n;
    send_request(make_request(OP_DATA, 8'h00, ROW_NONE, 7'd1), n);
    send_request(make_request(OP_DATA, 8'hFF, ROW_EXTRA, 7'd127), n);
    send_request(make_request(OP_DATA, 8'hA5, ROW_TOP, 7'd5), n);
    send_request(make_request(OP_CMD, 8'h00, ROW_NONE, 7'd0), n);
    send_request(make_request(OP_CMD, 8'hFF, ROW_BOTTOM, 7'd64), n);
    send_request(make_request(OP_CMD, 8'h5A, ROW_TOP, 7'd1), n);
    send_request(make_request(OP_INIT, 8'h00, ROW_NONE, 7'd1), n);
    send_request(make_request(OP_CURSOR, 8'h00, ROW_TOP, 7'd1), n);
    send_request(make_request(OP_CURSOR, 8'h00, ROW_TOP, 7'd64), n);
    send_request(make_request(OP_CURSOR, 8'h00, ROW_BOTTOM, 7'd1), n);
    send_request(make_request(OP_CURSOR, 8'h00, ROW_BOTTOM, 7'd40), n);
    // column zero wraps, large columns overlap the row bits
    send_request(make_request(OP_CURSOR, 8'h00, ROW_TOP, 7'd0), n);
    send_request(make_request(OP_CURSOR, 8'h00, ROW_BOTTOM, 7'd0), n);
    send_request(make_request(OP_CURSOR, 8'hFF, ROW_BOTTOM, 7'd127), n);
    send_request(make_request(OP_CURSOR, 8'h00, ROW_TOP, 7'd100), n);
    // rows that emit nothing
    send_request(make_request(OP_CURSOR, 8'h00, ROW_NONE, 7'd10), n);
    send_request(make_request(OP_CURSOR, 8'h00, ROW_EXTRA, 7'd5), n);
    send_request(make_request(OP_CLEAR, 8'h00, ROW_NONE, 7'd1), n);
    send_request(make_request(OP_HOME, 8'h00, ROW_NONE, 7'd1), n);
    send_request(make_request(OP_RSVD_A, 8'h3C, ROW_TOP, 7'd1), n);
    send_request(make_request(OP_RSVD_B, 8'hC3, ROW_BOTTOM, 7'd2), n);
    send_request(make_request(OP_DATA, 8'h41, ROW_NONE, 7'd1), n);
  endtask

  task automatic run_config_mix();
    int n;
    send_request(make_request(OP_INIT, 8'h00, ROW_NONE, 7'd1), n);
    send_request(make_request(OP_DATA, 8'hFF, ROW_NONE, 7'd1), n);
    send_request(make_request(OP_CLEAR, 8'h00, ROW_NONE, 7'd1), n);
    send_request(make_request(OP_CURSOR, 8'h00, ROW_BOTTOM, 7'd64), n);
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_PULSE, 20'd1);
    write_reg(CFG_POWER, 20'd0);
    run_config_mix();
    write_reg(CFG_PULSE, 20'd1000);
    write_reg(CFG_POWER, 20'd1000000);
    run_config_mix();
    write_reg(CFG_PULSE, 20'd1023);
    write_reg(CFG_POWER, 20'hFFFFF);
    run_config_mix();
    // upper bits of the pulse write are dropped, leaving a zero pulse
    write_reg(CFG_PULSE, {10'h3FF, 10'd0});
    write_reg(CFG_POWER, HOLD_W'($urandom_range(1000000)));
    run_config_mix();
  endtask

  task automatic test_random_traffic(input int target, input int idle_pct, input int stall_pct);
    int n;
    write_reg(CFG_PULSE, HOLD_W'($urandom_range(1000, 1)));
    write_reg(CFG_POWER, HOLD_W'($urandom_range(1000000)));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (target) begin
      send_request(rand_request(), n);
    end
  endtask

  // ---------------------------------------------------------------- result check
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pin_steps_q.size() == 0) begin
        $error("unexpected pin step: %p", out_data);
        n_fail++;
      end else begin
        want = pin_steps_q.pop_front();
        if (out_data.reg_select !== want.reg_select) begin
          $error("reg_select: expected %0h, got %0h", want.reg_select, out_data.reg_select);
          n_fail++;
        end
        if (out_data.read_not_write !== want.read_not_write) begin
          $error("read_not_write: expected %0h, got %0h", want.read_not_write,
                 out_data.read_not_write);
          n_fail++;
        end
        if (out_data.enable_pin !== want.enable_pin) begin
          $error("enable_pin: expected %0h, got %0h", want.enable_pin, out_data.enable_pin);
          n_fail++;
        end
        if (out_data.nibble !== want.nibble) begin
          $error("nibble: expected %0h, got %0h", want.nibble, out_data.nibble);
          n_fail++;
        end
        if (out_data.hold_us !== want.hold_us) begin
          $error("hold_us: expected %0d, got %0d", want.hold_us, out_data.hold_us);
          n_fail++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0h, got %0h", want.last, out_data.last);
          n_fail++;
        end
      end
    end
  end

  // Abort when no request, step or register write moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("char_lcd_nibble_interface: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_requests();
    test_register_extremes();
    test_random_traffic(18, 0, 0);
    test_random_traffic(18, 87, 0);
    test_random_traffic(18, 0, 87);
    test_random_traffic(18, 35, 35);
    in_valid <= 1'b0;
    while (pin_steps_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("char_lcd_nibble_interface: match");
    end else begin
      $display("char_lcd_nibble_interface: mismatch");
    end
    $finish;
  end

endmodule
